// ===== src/cbd_pkg.sv =====
// Shared types and constants for the console bus decoder.
// Depends on nothing; every other file takes names from here by scope.
`timescale 1ns / 1ps

package cbd_pkg;

    localparam int BASE_AW   = 10;      // 1K base RAM
    localparam int EXP_AW    = 15;      // 32K expansion RAM
    localparam int OFS_W     = 21;      // external offset port width
    localparam int SIZE_W    = 21;
    localparam int CFG_IDX_W = 2;

    localparam logic [15:0] BANK_SEL_BASE = 16'hffc0;
    localparam logic [7:0]  GRP_MASK      = 8'he0;
    localparam logic [7:0]  GRP_SEG_KEY   = 8'h80;
    localparam logic [7:0]  GRP_VIDEO     = 8'ha0;
    localparam logic [7:0]  GRP_SEG_JOY   = 8'hc0;
    localparam logic [7:0]  GRP_PAD       = 8'he0;
    localparam logic [7:0]  PORT_XSEL     = 8'h50;
    localparam logic [7:0]  PORT_XWR      = 8'h51;
    localparam logic [7:0]  PORT_XRD      = 8'h52;
    localparam logic [7:0]  PORT_EXP_HI   = 8'h53;
    localparam logic [7:0]  PORT_EXP_LO   = 8'h7f;
    localparam logic [7:0]  XSEL_MASK     = 8'h0f;
    localparam logic [7:0]  OPEN_BUS      = 8'hff;
    localparam logic [7:0]  EXP_RESET_VAL = 8'hff;
    localparam logic [SIZE_W-1:0] PAGE_8K  = 21'h02000;
    localparam logic [SIZE_W-1:0] PAGE_16K = 21'h04000;

    typedef enum logic [1:0] {
        ACT_MEM_RD  = 2'd0,
        ACT_MEM_WR  = 2'd1,
        ACT_PORT_RD = 2'd2,
        ACT_PORT_WR = 2'd3
    } act_t;

    typedef enum logic [3:0] {
        TGT_OPEN  = 4'd0,
        TGT_BASE  = 4'd1,
        TGT_EXP   = 4'd2,
        TGT_BIOS  = 4'd3,
        TGT_ROM   = 4'd4,
        TGT_VSTAT = 4'd5,
        TGT_VRD   = 4'd6,
        TGT_VCTL  = 4'd7,
        TGT_VWR   = 4'd8,
        TGT_SND   = 4'd9,
        TGT_XSEL  = 4'd10,
        TGT_XWR   = 4'd11,
        TGT_XRD   = 4'd12,
        TGT_PAD   = 4'd13
    } tgt_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CART_IS_MEGA = 2'd0,
        REG_ROM_SIZE     = 2'd1
    } reg_idx_t;

    typedef enum logic [1:0] {
        RD_FIXED = 2'd0,
        RD_BASE  = 2'd1,
        RD_EXP   = 2'd2
    } rd_src_t;

    typedef struct packed {
        tgt_t             target;
        rd_src_t          rd_src;
        logic [7:0]       read_data;
        logic [OFS_W-1:0] ext_offset;
        logic             pad_port;
        logic [7:0]       forward_data;
    } dec_t;

    typedef struct packed {
        logic               base_we;
        logic               base_re;
        logic               exp_we;
        logic               exp_re;
        logic [BASE_AW-1:0] base_addr;
        logic [EXP_AW-1:0]  exp_addr;
        logic [7:0]         wdata;
    } mem_req_t;

endpackage

// ===== src/cbd_ifs.sv =====
// Valid/ready channel interfaces: bus request, decode result, register write.
// Depends on cbd_pkg for widths.
`timescale 1ns / 1ps

interface cbd_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [15:0] address;
    logic [7:0]  write_data;
    logic [15:0] pad_word;

    modport source (output valid, action, address, write_data, pad_word, input ready);
    modport sink   (input valid, action, address, write_data, pad_word, output ready);
endinterface

interface cbd_rsp_if;
    logic                      valid;
    logic                      ready;
    logic [3:0]                target;
    logic [7:0]                read_data;
    logic [cbd_pkg::OFS_W-1:0] ext_offset;
    logic                      pad_port;
    logic [7:0]                forward_data;

    modport source (output valid, target, read_data, ext_offset, pad_port, forward_data,
                    input ready);
    modport sink   (input valid, target, read_data, ext_offset, pad_port, forward_data,
                    output ready);
endinterface

interface cbd_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [cbd_pkg::CFG_IDX_W-1:0] index;
    logic [cbd_pkg::SIZE_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/cbd_decode.sv =====
// Address/port decode, mapping registers, bank select and RAM request generation.
// Depends on cbd_pkg.
`timescale 1ns / 1ps

module cbd_decode #(
    parameter int ROM_OFFSET_BITS = 21
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            accept,
    input  logic [1:0]                      action,
    input  logic [15:0]                     address,
    input  logic [7:0]                      write_data,
    input  logic [15:0]                     pad_word,
    input  logic                            cfg_we,
    input  logic [cbd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [cbd_pkg::SIZE_W-1:0]      cfg_data,
    output cbd_pkg::dec_t                   dec,
    output cbd_pkg::mem_req_t               mem_req
);

    logic                          mega_reg, mega_next;
    logic [cbd_pkg::SIZE_W-1:0]    size_reg, size_next;
    logic                          strobe_reg, strobe_next;
    logic                          upper_reg, upper_next;
    logic                          lower_reg, lower_next;
    logic [ROM_OFFSET_BITS-1:0]    bank_reg, bank_next;

    logic [7:0]                    port;
    logic [7:0]                    pages;
    logic [6:0]                    bank_mask;
    logic [ROM_OFFSET_BITS-1:0]    bank_sel_base;
    logic                          past_rom;
    logic [cbd_pkg::OFS_W-1:0]     cart_ofs;
    logic [cbd_pkg::OFS_W-1:0]     page_base;
    logic [cbd_pkg::OFS_W-1:0]     ofs_sum;
    cbd_pkg::mem_req_t             req;

    assign port = address[7:0];

    // 8K page count rounded up, kept in 8 bits; mask is (pages/2 - 1)
    assign pages = size_reg[20:13] + 8'(|size_reg[12:0]);
    assign bank_mask = pages[7:1] - 7'd1;
    assign bank_sel_base = ROM_OFFSET_BITS'({address[6:0] & bank_mask, 14'b0});
    assign past_rom = {6'b0, address} >= ({1'b0, size_reg} + 22'h08000);

    // bank_next already holds a select made by this same access
    always_comb
    begin
        page_base = '0;
        case (address[14:13])
            2'd0:    page_base = size_reg - cbd_pkg::PAGE_16K;
            2'd1:    page_base = size_reg - cbd_pkg::PAGE_8K;
            2'd2:    page_base = cbd_pkg::OFS_W'(bank_next);
            default: page_base = cbd_pkg::OFS_W'(bank_next) + cbd_pkg::PAGE_8K;
        endcase
        if (mega_reg)
            ofs_sum = page_base + cbd_pkg::OFS_W'(address[12:0]);
        else
            ofs_sum = cbd_pkg::OFS_W'(address[14:0]);
        cart_ofs = cbd_pkg::OFS_W'(ofs_sum[ROM_OFFSET_BITS-1:0]);
    end

    always_comb
    begin
        dec          = '0;
        dec.target   = cbd_pkg::TGT_OPEN;
        dec.rd_src   = cbd_pkg::RD_FIXED;
        req          = '0;
        req.base_addr = address[cbd_pkg::BASE_AW-1:0];
        req.exp_addr  = address[cbd_pkg::EXP_AW-1:0];
        req.wdata     = write_data;
        strobe_next  = strobe_reg;
        upper_next   = upper_reg;
        lower_next   = lower_reg;
        bank_next    = bank_reg;

        case (cbd_pkg::act_t'(action))
            cbd_pkg::ACT_MEM_RD:
            begin
                if (lower_reg && address[15:13] == 3'd0) begin
                    dec.target = cbd_pkg::TGT_EXP;
                    dec.rd_src = cbd_pkg::RD_EXP;
                    req.exp_re = 1'b1;
                end else if (address[15:13] == 3'd0) begin
                    dec.target     = cbd_pkg::TGT_BIOS;
                    dec.ext_offset = cbd_pkg::OFS_W'(address);
                end else if (upper_reg && !address[15]) begin
                    dec.target = cbd_pkg::TGT_EXP;
                    dec.rd_src = cbd_pkg::RD_EXP;
                    req.exp_re = 1'b1;
                end else if (address[15:13] < 3'd3) begin
                    dec.read_data = cbd_pkg::OPEN_BUS;
                end else if (!address[15]) begin
                    dec.target  = cbd_pkg::TGT_BASE;
                    dec.rd_src  = cbd_pkg::RD_BASE;
                    req.base_re = 1'b1;
                end else begin
                    if (mega_reg && address >= cbd_pkg::BANK_SEL_BASE)
                        bank_next = bank_sel_base;
                    if (past_rom) begin
                        dec.read_data = cbd_pkg::OPEN_BUS;
                    end else begin
                        dec.target     = cbd_pkg::TGT_ROM;
                        dec.ext_offset = cart_ofs;
                    end
                end
            end
            cbd_pkg::ACT_MEM_WR:
            begin
                if (lower_reg && address[15:13] == 3'd0) begin
                    dec.target = cbd_pkg::TGT_EXP;
                    req.exp_we = 1'b1;
                end else if (upper_reg && address[15:13] != 3'd0 && !address[15]) begin
                    dec.target = cbd_pkg::TGT_EXP;
                    req.exp_we = 1'b1;
                end else if (address[15:13] >= 3'd3 && !address[15]) begin
                    dec.target  = cbd_pkg::TGT_BASE;
                    req.base_we = 1'b1;
                end
            end
            cbd_pkg::ACT_PORT_RD:
            begin
                if ((port & cbd_pkg::GRP_MASK) == cbd_pkg::GRP_VIDEO) begin
                    dec.target = port[0] ? cbd_pkg::TGT_VSTAT : cbd_pkg::TGT_VRD;
                end else if ((port & cbd_pkg::GRP_MASK) == cbd_pkg::GRP_PAD) begin
                    dec.target    = cbd_pkg::TGT_PAD;
                    dec.pad_port  = port[1];
                    dec.read_data = strobe_reg ? ~pad_word[15:8] : ~pad_word[7:0];
                end else if (port == cbd_pkg::PORT_XRD) begin
                    dec.target = cbd_pkg::TGT_XRD;
                end else begin
                    dec.read_data = cbd_pkg::OPEN_BUS;
                end
            end
            default:
            begin
                if ((port & cbd_pkg::GRP_MASK) == cbd_pkg::GRP_SEG_KEY) begin
                    strobe_next = 1'b0;
                end else if ((port & cbd_pkg::GRP_MASK) == cbd_pkg::GRP_VIDEO) begin
                    dec.target       = port[0] ? cbd_pkg::TGT_VCTL : cbd_pkg::TGT_VWR;
                    dec.forward_data = write_data;
                end else if ((port & cbd_pkg::GRP_MASK) == cbd_pkg::GRP_SEG_JOY) begin
                    strobe_next = 1'b1;
                end else if ((port & cbd_pkg::GRP_MASK) == cbd_pkg::GRP_PAD) begin
                    dec.target       = cbd_pkg::TGT_SND;
                    dec.forward_data = write_data;
                end else if (port == cbd_pkg::PORT_XSEL) begin
                    dec.target       = cbd_pkg::TGT_XSEL;
                    dec.forward_data = write_data & cbd_pkg::XSEL_MASK;
                end else if (port == cbd_pkg::PORT_XWR) begin
                    dec.target       = cbd_pkg::TGT_XWR;
                    dec.forward_data = write_data;
                end else if (port == cbd_pkg::PORT_EXP_HI) begin
                    upper_next = 1'b1;
                end else if (port == cbd_pkg::PORT_EXP_LO) begin
                    lower_next = !write_data[1];
                end
            end
        endcase

        mem_req         = req;
        mem_req.base_we = req.base_we & accept;
        mem_req.base_re = req.base_re & accept;
        mem_req.exp_we  = req.exp_we & accept;
        mem_req.exp_re  = req.exp_re & accept;
    end

    always_comb
    begin
        mega_next = mega_reg;
        size_next = size_reg;
        if (cfg_we) begin
            case (cfg_index)
                cbd_pkg::REG_CART_IS_MEGA: mega_next = cfg_data[0];
                cbd_pkg::REG_ROM_SIZE:     size_next = cfg_data;
                default:                   ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mega_reg   <= 1'b0;
            size_reg   <= '0;
            strobe_reg <= 1'b0;
            upper_reg  <= 1'b0;
            lower_reg  <= 1'b0;
            bank_reg   <= '0;
        end else begin
            mega_reg <= mega_next;
            size_reg <= size_next;
            if (accept) begin
                strobe_reg <= strobe_next;
                upper_reg  <= upper_next;
                lower_reg  <= lower_next;
                bank_reg   <= bank_next;
            end
        end
    end

endmodule

// ===== src/cbd_mem.sv =====
// Base RAM and expansion RAM, synchronous with registered read data.
// Expansion RAM is swept to 0xff after reset. Depends on cbd_pkg.
`timescale 1ns / 1ps

module cbd_mem (
    input  logic              clk,
    input  logic              rst_n,
    input  cbd_pkg::mem_req_t req,
    output logic [7:0]        base_rdata,
    output logic [7:0]        exp_rdata,
    output logic              clr_busy
);

    localparam int BASE_DEPTH = 1 << cbd_pkg::BASE_AW;
    localparam int EXP_DEPTH  = 1 << cbd_pkg::EXP_AW;

    logic [7:0] base_mem [BASE_DEPTH];
    logic [7:0] exp_mem  [EXP_DEPTH];

    logic [7:0]                base_rdata_reg;
    logic [7:0]                exp_rdata_reg;
    logic                      clr_busy_reg, clr_busy_next;
    logic [cbd_pkg::EXP_AW-1:0] clr_addr_reg, clr_addr_next;

    assign clr_addr_next = clr_addr_reg + cbd_pkg::EXP_AW'(1);
    assign clr_busy_next = clr_busy_reg && (clr_addr_reg != '1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clr_busy_reg)
        begin
            clr_busy_reg <= clr_busy_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.base_we)
            base_mem[req.base_addr] <= req.wdata;
        if (req.base_re)
            base_rdata_reg <= base_mem[req.base_addr];
    end

    // no requests arrive while the sweep runs
    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
            exp_mem[clr_addr_reg] <= cbd_pkg::EXP_RESET_VAL;
        else if (req.exp_we)
            exp_mem[req.exp_addr] <= req.wdata;
        if (req.exp_re)
            exp_rdata_reg <= exp_mem[req.exp_addr];
    end

    assign base_rdata = base_rdata_reg;
    assign exp_rdata  = exp_rdata_reg;
    assign clr_busy   = clr_busy_reg;

endmodule

// ===== src/console_bus_decoder_bank_switch.sv =====
// Top level of the console bus decoder: decode stage, RAM stage, output register.
// Depends on cbd_pkg, cbd_ifs, cbd_decode and cbd_mem.
`timescale 1ns / 1ps

// Takes one CPU bus request per clock while req_ch.ready is high and returns
// one decode result per request through the stage-one and output registers.
// The request is decoded and any RAM access is issued at the accepting edge;
// when stage one moves, the registered RAM data is merged and the result enters
// the output register, so a new request is taken while a finished result still
// waits. After reset the expansion RAM is swept to 0xff, one byte per cycle,
// which holds req_ch.ready low until the sweep ends; register writes are taken
// throughout and cfg.ready is always high.
module console_bus_decoder_bank_switch #(
    parameter int ROM_OFFSET_BITS = 21
) (
    input  logic      clk,
    input  logic      rst_n,
    cbd_req_if.sink   req_ch,
    cbd_rsp_if.source rsp_ch,
    cbd_cfg_if.sink   cfg
);

    cbd_pkg::dec_t     dec;
    cbd_pkg::mem_req_t mem_req;
    logic [7:0]        base_rdata;
    logic [7:0]        exp_rdata;
    logic              clr_busy;
    logic              accept;
    logic              s1_move;

    logic              s1_valid_reg, s1_valid_next;
    cbd_pkg::dec_t     s1_dec_reg;
    logic              out_valid_reg, out_valid_next;
    cbd_pkg::dec_t     out_dec_reg, out_dec_next;

    assign s1_move      = !out_valid_reg || rsp_ch.ready;
    assign req_ch.ready = !clr_busy && (!s1_valid_reg || s1_move);
    assign accept       = req_ch.valid && req_ch.ready;
    assign cfg.ready    = 1'b1;

    cbd_decode #(
        .ROM_OFFSET_BITS (ROM_OFFSET_BITS)
    ) u_decode (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .action     (req_ch.action),
        .address    (req_ch.address),
        .write_data (req_ch.write_data),
        .pad_word   (req_ch.pad_word),
        .cfg_we     (cfg.valid),
        .cfg_index  (cfg.index),
        .cfg_data   (cfg.data),
        .dec        (dec),
        .mem_req    (mem_req)
    );

    cbd_mem u_mem (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (mem_req),
        .base_rdata (base_rdata),
        .exp_rdata  (exp_rdata),
        .clr_busy   (clr_busy)
    );

    always_comb
    begin
        out_dec_next = s1_dec_reg;
        case (s1_dec_reg.rd_src)
            cbd_pkg::RD_BASE: out_dec_next.read_data = base_rdata;
            cbd_pkg::RD_EXP:  out_dec_next.read_data = exp_rdata;
            default:          out_dec_next.read_data = s1_dec_reg.read_data;
        endcase

        if (accept)
            s1_valid_next = 1'b1;
        else if (s1_move)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;

        if (s1_valid_reg && s1_move)
            out_valid_next = 1'b1;
        else if (rsp_ch.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            s1_dec_reg <= dec;
        if (s1_valid_reg && s1_move)
            out_dec_reg <= out_dec_next;
    end

    assign rsp_ch.valid        = out_valid_reg;
    assign rsp_ch.target       = out_dec_reg.target;
    assign rsp_ch.read_data    = out_dec_reg.read_data;
    assign rsp_ch.ext_offset   = out_dec_reg.ext_offset;
    assign rsp_ch.pad_port     = out_dec_reg.pad_port;
    assign rsp_ch.forward_data = out_dec_reg.forward_data;

    // no request may be taken while the expansion RAM sweep runs
    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clr_busy |-> !req_ch.ready)
        else $error("request taken during expansion RAM clear");

    // a held stage-one request must block new requests
    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && out_valid_reg && !rsp_ch.ready |-> !req_ch.ready)
        else $error("request taken while pipeline is full");

    // stage one entry always reaches the output register when it moves
    a_s1_moves: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s1_move |=> rsp_ch.valid)
        else $error("stage one result lost");

    a_pad_port_only_on_pad: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_ch.valid && rsp_ch.target != cbd_pkg::TGT_PAD |-> !rsp_ch.pad_port)
        else $error("pad port set on non-pad result");

endmodule
